// ----- rtl/wnts_pkg.sv -----
// wnts_pkg: shared types, constants and codes for the weighted nearest top-k search unit
// no dependencies; used by wnts_dist, wnts_cell, weighted_nearest_topk_search_unit and tb
package wnts_pkg;

   // default sizing of the top level
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int MAX_KEEP_DEF = 4;

   // field widths
   localparam int LANES = 4;
   localparam int VAL_W = 16;
   localparam int KIND_W = 8;
   localparam int DIST_W = 50;
   localparam int OUT_DIST_W = 52;
   localparam int IDX_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;
   // scan position carried with a candidate, wide enough for the largest table
   localparam int SEQ_W = 10;

   // latency from table read issue to the head of the sorting chain
   localparam int DIST_LAT = 5;

   // request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_KIND = 2'd2;

   // four 16-bit lanes, temperature in lane 0
   typedef logic [LANES-1:0][VAL_W-1:0] vec4_type;

   // one table entry
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      vec4_type centres;
      vec4_type weights;
   } entry_type;

   // a scored candidate moving through the chain
   typedef struct packed {
      logic valid;
      logic [DIST_W-1:0] score;
      logic [SEQ_W-1:0] seq;
      logic [KIND_W-1:0] kind;
   } cand_type;

endpackage

// ----- rtl/wnts_dist.sv -----
// wnts_dist: four-stage weighted squared distance pipeline (diff, square, weight, sum)
// depends on wnts_pkg
module wnts_dist (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [wnts_pkg::SEQ_W-1:0] in_seq,
   input  wnts_pkg::vec4_type sample,
   input  wnts_pkg::entry_type entry,
   output wnts_pkg::cand_type cand_out
);

   logic [wnts_pkg::LANES-1:0][16:0] diff_w;
   logic [wnts_pkg::LANES-1:0][15:0] abs_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [wnts_pkg::LANES-1:0][15:0] abs_ff;
   logic [wnts_pkg::LANES-1:0][31:0] sq_ff;
   logic [wnts_pkg::LANES-1:0][47:0] prod_ff;
   wnts_pkg::vec4_type w1_ff, w2_ff;
   logic [wnts_pkg::KIND_W-1:0] k1_ff, k2_ff, k3_ff, k4_ff;
   logic [wnts_pkg::SEQ_W-1:0] s1_ff, s2_ff, s3_ff, s4_ff;
   logic [wnts_pkg::DIST_W-1:0] sum_ff;
   logic [wnts_pkg::DIST_W-1:0] sum_in;

   // absolute difference per lane, exact in 16 bits
   always_comb begin
      for (int i = 0; i < wnts_pkg::LANES; i++) begin
         diff_w[i] = {sample[i][15], sample[i]} - {entry.centres[i][15], entry.centres[i]};
         abs_in[i] = diff_w[i][16] ? 16'(-diff_w[i]) : diff_w[i][15:0];
      end
   end

   // sum of the four weighted terms
   always_comb begin
      sum_in = 50'(prod_ff[0]) + 50'(prod_ff[1]) + 50'(prod_ff[2]) + 50'(prod_ff[3]);
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      abs_ff <= abs_in;
      w1_ff <= entry.weights;
      k1_ff <= entry.kind;
      s1_ff <= in_seq;
      for (int i = 0; i < wnts_pkg::LANES; i++) begin
         sq_ff[i] <= 32'(abs_ff[i]) * 32'(abs_ff[i]);
         prod_ff[i] <= 48'(w2_ff[i]) * 48'(sq_ff[i]);
      end
      w2_ff <= w1_ff;
      k2_ff <= k1_ff;
      k3_ff <= k2_ff;
      s2_ff <= s1_ff;
      s3_ff <= s2_ff;
      sum_ff <= sum_in;
      k4_ff <= k3_ff;
      s4_ff <= s3_ff;
   end

   assign cand_out.valid = v4_ff;
   assign cand_out.score = sum_ff;
   assign cand_out.seq = s4_ff;
   assign cand_out.kind = k4_ff;

endmodule

// ----- rtl/wnts_cell.sv -----
// wnts_cell: one insertion cell of the sorting chain, keeps one candidate, passes the larger on
// depends on wnts_pkg
module wnts_cell (
   input  logic clock,
   input  logic reset,
   input  logic clear,
   input  wnts_pkg::cand_type cand_in,
   output wnts_pkg::cand_type held,
   output wnts_pkg::cand_type pass
);

   wnts_pkg::cand_type held_ff, held_in;
   wnts_pkg::cand_type pass_ff, pass_in;

   // keep the smaller, on equal distance the earlier scan position stays
   always_comb begin
      held_in = held_ff;
      pass_in = cand_in;
      pass_in.valid = 1'b0;
      if (cand_in.valid) begin
         if (!held_ff.valid) begin
            held_in = cand_in;
         end else if ((cand_in.score < held_ff.score)
                      || ((cand_in.score == held_ff.score) && (cand_in.seq < held_ff.seq))) begin
            held_in = cand_in;
            pass_in = held_ff;
         end else begin
            pass_in = cand_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         held_ff <= '0;
         pass_ff <= '0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

   assign held = held_ff;
   assign pass = pass_ff;

endmodule

// ----- rtl/weighted_nearest_topk_search_unit.sv -----
// weighted_nearest_topk_search_unit: top level with entry table, scan control and sorting chain
// depends on wnts_pkg, wnts_dist and wnts_cell
//
//   channel   ports                                   handshake
//   request   start, busy, req_*                      taken when start and not busy
//   result    rsp_strobe, rsp_*                       one cycle per result, no back-pressure
//   csr       csr_valid, csr_ready, csr_index/data    written when valid and ready
//
// a load is written to the table when it is taken and gives no result
// a query scans n entries and gives k results; the table read port feeds one entry per cycle
// to the distance pipeline and the sorting chain
// an empty scan goes straight to the emit state and gives a single not-found result
// reset is synchronous; the table holds garbage until loaded and has no clearing pass
// results cannot be stalled; csr writes are always ready
module weighted_nearest_topk_search_unit #(
   parameter int TABLE_DEPTH = wnts_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_KEEP = wnts_pkg::MAX_KEEP_DEF
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic start,
   output logic busy,
   input  logic req_type,
   input  logic [wnts_pkg::IDX_W-1:0] req_entry_index,
   input  logic [wnts_pkg::KIND_W-1:0] req_entry_kind,
   input  logic signed [wnts_pkg::VAL_W-1:0] req_value_temperature,
   input  logic signed [wnts_pkg::VAL_W-1:0] req_value_humidity,
   input  logic signed [wnts_pkg::VAL_W-1:0] req_value_erosion,
   input  logic signed [wnts_pkg::VAL_W-1:0] req_value_weirdness,
   input  logic [wnts_pkg::VAL_W-1:0] req_weight_temperature,
   input  logic [wnts_pkg::VAL_W-1:0] req_weight_humidity,
   input  logic [wnts_pkg::VAL_W-1:0] req_weight_erosion,
   input  logic [wnts_pkg::VAL_W-1:0] req_weight_weirdness,
   // result channel
   output logic rsp_strobe,
   output logic [1:0] rsp_rank,
   output logic [wnts_pkg::KIND_W-1:0] rsp_result_kind,
   output logic [wnts_pkg::OUT_DIST_W-1:0] rsp_distance,
   output logic rsp_found,
   output logic rsp_last,
   // configuration channel
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [wnts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wnts_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = $clog2(MAX_KEEP + 1);
   localparam int KIW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int DRAIN_CYCLES = wnts_pkg::DIST_LAT + MAX_KEEP + 1;
   localparam int DW = $clog2(DRAIN_CYCLES + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [6:0] entry_count_ff;
   logic [2:0] keep_count_ff;
   logic [wnts_pkg::KIND_W-1:0] default_kind_ff;

   // query context
   wnts_pkg::vec4_type sample_ff, sample_in;
   logic [CW-1:0] scan_n_ff, scan_n_in;
   logic [CW-1:0] scan_cnt_ff, scan_cnt_in;
   logic [KW-1:0] total_ff, total_in;
   logic empty_ff, empty_in;
   logic [DW-1:0] drain_cnt_ff, drain_cnt_in;
   logic [KIW-1:0] rank_cnt_ff, rank_cnt_in;

   // table
   wnts_pkg::entry_type table_mem [TABLE_DEPTH];
   wnts_pkg::entry_type rd_data_ff;
   logic [wnts_pkg::SEQ_W-1:0] rd_seq_ff;
   logic rd_valid_ff;
   logic issue;
   logic load_we;
   logic query_go;
   wnts_pkg::entry_type load_entry;

   // result registers
   logic rsp_strobe_ff, rsp_strobe_in;
   logic [1:0] rsp_rank_ff, rsp_rank_in;
   logic [wnts_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [wnts_pkg::OUT_DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic rsp_found_ff, rsp_found_in;
   logic rsp_last_ff, rsp_last_in;

   // chain
   wnts_pkg::cand_type chain [MAX_KEEP+1];
   wnts_pkg::cand_type held [MAX_KEEP];
   wnts_pkg::cand_type pick;

   // query setup values
   int n_eff;
   int k_eff;
   int tot_eff;

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign load_we = start && !busy && (req_type == wnts_pkg::REQ_LOAD)
                    && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign query_go = start && !busy && (req_type == wnts_pkg::REQ_QUERY);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         keep_count_ff <= 3'd1;
         default_kind_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wnts_pkg::CSR_ENTRY_COUNT: entry_count_ff <= csr_data[6:0];
            wnts_pkg::CSR_KEEP_COUNT: keep_count_ff <= csr_data[2:0];
            wnts_pkg::CSR_DEFAULT_KIND: default_kind_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // load entry packing
   always_comb begin
      load_entry.kind = req_entry_kind;
      load_entry.centres[0] = req_value_temperature;
      load_entry.centres[1] = req_value_humidity;
      load_entry.centres[2] = req_value_erosion;
      load_entry.centres[3] = req_value_weirdness;
      load_entry.weights[0] = req_weight_temperature;
      load_entry.weights[1] = req_weight_humidity;
      load_entry.weights[2] = req_weight_erosion;
      load_entry.weights[3] = req_weight_weirdness;
   end

   // table write and registered read, scan position travels with the entry
   always_ff @(posedge clock) begin
      if (load_we) begin
         table_mem[AW'(req_entry_index)] <= load_entry;
      end
      rd_data_ff <= table_mem[scan_cnt_ff[AW-1:0]];
      rd_seq_ff <= wnts_pkg::SEQ_W'(scan_cnt_ff[AW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
      end
   end

   // saturated scan length and result count
   always_comb begin
      n_eff = (32'(entry_count_ff) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(entry_count_ff);
      k_eff = (keep_count_ff == 3'd0) ? 1 : 32'(keep_count_ff);
      if (k_eff > MAX_KEEP) begin
         k_eff = MAX_KEEP;
      end
      tot_eff = (n_eff < k_eff) ? n_eff : k_eff;
   end

   // distance pipeline
   wnts_dist u_dist (
      .clock(clock),
      .reset(reset),
      .in_valid(rd_valid_ff),
      .in_seq(rd_seq_ff),
      .sample(sample_ff),
      .entry(rd_data_ff),
      .cand_out(chain[0])
   );

   // sorting chain
   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
      wnts_cell u_cell (
         .clock(clock),
         .reset(reset),
         .clear(query_go),
         .cand_in(chain[g]),
         .held(held[g]),
         .pass(chain[g+1])
      );
   end

   assign pick = held[rank_cnt_ff];

   // sequencer
   always_comb begin
      state_in = state_ff;
      sample_in = sample_ff;
      scan_n_in = scan_n_ff;
      scan_cnt_in = scan_cnt_ff;
      total_in = total_ff;
      empty_in = empty_ff;
      drain_cnt_in = drain_cnt_ff;
      rank_cnt_in = rank_cnt_ff;
      issue = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_rank_in = 2'(rank_cnt_ff);
      rsp_kind_in = pick.kind;
      rsp_dist_in = wnts_pkg::OUT_DIST_W'(pick.score);
      rsp_found_in = 1'b1;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               sample_in[0] = req_value_temperature;
               sample_in[1] = req_value_humidity;
               sample_in[2] = req_value_erosion;
               sample_in[3] = req_value_weirdness;
               scan_n_in = CW'(n_eff);
               scan_cnt_in = '0;
               rank_cnt_in = '0;
               if (n_eff == 0) begin
                  empty_in = 1'b1;
                  total_in = KW'(1);
                  state_in = ST_EMIT;
               end else begin
                  empty_in = 1'b0;
                  total_in = KW'(tot_eff);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            issue = 1'b1;
            scan_cnt_in = scan_cnt_ff + CW'(1);
            if (scan_cnt_ff + CW'(1) == scan_n_ff) begin
               drain_cnt_in = DW'(DRAIN_CYCLES);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_cnt_in = drain_cnt_ff - DW'(1);
            if (drain_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            if (empty_ff) begin
               rsp_kind_in = default_kind_ff;
               rsp_dist_in = '1;
               rsp_found_in = 1'b0;
            end
            if (KW'(rank_cnt_ff) + KW'(1) == total_ff) begin
               rsp_last_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rank_cnt_in = rank_cnt_ff + KIW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_cnt_ff <= '0;
         drain_cnt_ff <= '0;
         rank_cnt_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         drain_cnt_ff <= drain_cnt_in;
         rank_cnt_ff <= rank_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // query context and result payload
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      scan_n_ff <= scan_n_in;
      total_ff <= total_in;
      empty_ff <= empty_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_rank = rsp_rank_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_last = rsp_last_ff;

   // results only come out of the emit state
   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_EMIT))
      else $error("result strobe without emit state");

   // the last result of a query returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_ff) |-> (state_ff == ST_IDLE))
      else $error("last result but sequencer not idle");

   // a query on a non-empty table starts scanning
   a_query_scan: assert property (@(posedge clock) disable iff (reset)
      (query_go && (entry_count_ff != '0)) |=> (state_ff == ST_SCAN))
      else $error("query did not start a scan");

   // a not-found result is the only result of its query
   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_found_ff) |-> (rsp_last_ff && (rsp_rank_ff == 2'd0)))
      else $error("not-found result is not a single rank zero result");

   // no table entry reaches the chain while the sequencer is idle
   a_chain_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !chain[0].valid)
      else $error("candidate in chain while idle");

endmodule

// ----- dv/tb.sv -----
// tb: self-checking testbench for weighted_nearest_topk_search_unit
// depends on wnts_pkg and the top level; predicts every query result and checks it in order
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = wnts_pkg::TABLE_DEPTH_DEF;
   localparam int MAX_KEEP = wnts_pkg::MAX_KEEP_DEF;
   // idle cycles before a csr write: a full scan plus pipeline and chain
   localparam int SETTLE = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [wnts_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one request as seen on the request ports
   typedef struct packed {
      logic typ;
      logic [wnts_pkg::IDX_W-1:0] slot;
      logic [wnts_pkg::KIND_W-1:0] kind;
      wnts_pkg::vec4_type vals;
      wnts_pkg::vec4_type wts;
   } request_type;

   // one result as seen on the result ports
   typedef struct packed {
      logic [1:0] rank;
      logic [wnts_pkg::KIND_W-1:0] kind;
      logic [wnts_pkg::OUT_DIST_W-1:0] distance;
      logic found;
      logic last;
   } hit_type;

   // table copy, register copy and queue of predicted nearest hits
   class nearest_checker;
      wnts_pkg::entry_type slots [TABLE_DEPTH];
      int unsigned scan_count = 0;
      int unsigned keep_limit = 1;
      logic [wnts_pkg::KIND_W-1:0] fallback_kind = '0;
      hit_type expected_hits [$];
      int failures = 0;

      function int pending();
         return expected_hits.size();
      endfunction

      function void write_register(logic [wnts_pkg::CSR_IDX_W-1:0] idx,
                                   logic [wnts_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            wnts_pkg::CSR_ENTRY_COUNT: scan_count = data[6:0];
            wnts_pkg::CSR_KEEP_COUNT: keep_limit = data[2:0];
            wnts_pkg::CSR_DEFAULT_KIND: fallback_kind = data;
            default: ;
         endcase
      endfunction

      // sum over lanes of weight * (sample - centre)^2, exact
      function logic [63:0] weighted_distance(wnts_pkg::vec4_type sample,
                                              wnts_pkg::entry_type e);
         logic [63:0] sum;
         int diff;
         longint unsigned mag;
         sum = '0;
         for (int lane = 0; lane < wnts_pkg::LANES; lane++) begin
            diff = int'($signed(sample[lane])) - int'($signed(e.centres[lane]));
            mag = (diff < 0) ? -diff : diff;
            sum += 64'(e.weights[lane]) * mag * mag;
         end
         return sum;
      endfunction

      function void note_request(request_type r);
         logic [63:0] best_d [MAX_KEEP];
         logic [wnts_pkg::KIND_W-1:0] best_k [MAX_KEEP];
         logic [63:0] d;
         int n, k, filled, pos;
         if (r.typ == wnts_pkg::REQ_LOAD) begin
            slots[r.slot] = '{kind: r.kind, centres: r.vals, weights: r.wts};
            return;
         end
         n = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : scan_count;
         k = (keep_limit == 0) ? 1 : ((keep_limit > MAX_KEEP) ? MAX_KEEP : keep_limit);
         // empty scan reports the default kind
         if (n == 0) begin
            expected_hits.push_back(hit_type'{rank: 2'd0, kind: fallback_kind,
               distance: {wnts_pkg::OUT_DIST_W{1'b1}}, found: 1'b0, last: 1'b1});
            return;
         end
         // insertion into a sorted list, earlier entry wins a tie
         filled = 0;
         for (int i = 0; i < n; i++) begin
            d = weighted_distance(r.vals, slots[i]);
            if (filled == k && d >= best_d[filled-1]) continue;
            pos = (filled < k) ? filled : k - 1;
            while (pos > 0 && best_d[pos-1] > d) begin
               best_d[pos] = best_d[pos-1];
               best_k[pos] = best_k[pos-1];
               pos--;
            end
            best_d[pos] = d;
            best_k[pos] = slots[i].kind;
            if (filled < k) filled++;
         end
         for (int i = 0; i < filled; i++)
            expected_hits.push_back(hit_type'{rank: 2'(i), kind: best_k[i],
               distance: best_d[i][wnts_pkg::OUT_DIST_W-1:0], found: 1'b1,
               last: (i == filled - 1)});
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_result(hit_type got);
         hit_type want;
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual rank %0d kind %0h dist %0h",
               $time, got.rank, got.kind, got.distance);
            failures++;
            return;
         end
         want = expected_hits.pop_front();
         compare_field("rank", want.rank, got.rank);
         compare_field("kind", want.kind, got.kind);
         compare_field("distance", want.distance, got.distance);
         compare_field("found", want.found, got.found);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = 1'b0;
   logic [wnts_pkg::IDX_W-1:0] req_entry_index = '0;
   logic [wnts_pkg::KIND_W-1:0] req_entry_kind = '0;
   logic signed [wnts_pkg::VAL_W-1:0] req_value_temperature = '0;
   logic signed [wnts_pkg::VAL_W-1:0] req_value_humidity = '0;
   logic signed [wnts_pkg::VAL_W-1:0] req_value_erosion = '0;
   logic signed [wnts_pkg::VAL_W-1:0] req_value_weirdness = '0;
   logic [wnts_pkg::VAL_W-1:0] req_weight_temperature = '0;
   logic [wnts_pkg::VAL_W-1:0] req_weight_humidity = '0;
   logic [wnts_pkg::VAL_W-1:0] req_weight_erosion = '0;
   logic [wnts_pkg::VAL_W-1:0] req_weight_weirdness = '0;
   logic rsp_strobe;
   logic [1:0] rsp_rank;
   logic [wnts_pkg::KIND_W-1:0] rsp_result_kind;
   logic [wnts_pkg::OUT_DIST_W-1:0] rsp_distance;
   logic rsp_found;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [wnts_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wnts_pkg::CSR_DATA_W-1:0] csr_data = '0;

   nearest_checker board = new();
   bit loaded [TABLE_DEPTH] = '{default: 1'b0};
   bit full_scan_done = 1'b0;
   int sender_idle_pct = 0;
   int idle_cycles = 0;

   weighted_nearest_topk_search_unit #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_KEEP(MAX_KEEP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_entry_index(req_entry_index),
      .req_entry_kind(req_entry_kind),
      .req_value_temperature(req_value_temperature),
      .req_value_humidity(req_value_humidity),
      .req_value_erosion(req_value_erosion),
      .req_value_weirdness(req_value_weirdness),
      .req_weight_temperature(req_weight_temperature),
      .req_weight_humidity(req_weight_humidity),
      .req_weight_erosion(req_weight_erosion),
      .req_weight_weirdness(req_weight_weirdness),
      .rsp_strobe(rsp_strobe),
      .rsp_rank(rsp_rank),
      .rsp_result_kind(rsp_result_kind),
      .rsp_distance(rsp_distance),
      .rsp_found(rsp_found),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // every strobed result is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result(hit_type'{rank: rsp_rank, kind: rsp_result_kind,
            distance: rsp_distance, found: rsp_found, last: rsp_last});
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // value lanes biased to extremes and a narrow band that makes ties
   function automatic logic [wnts_pkg::VAL_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [wnts_pkg::VAL_W-1:0] rand_weight();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h1000;
         3: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic request_type uniform_request(logic typ,
      logic [wnts_pkg::IDX_W-1:0] slot, logic [wnts_pkg::KIND_W-1:0] kind,
      logic [wnts_pkg::VAL_W-1:0] val, logic [wnts_pkg::VAL_W-1:0] wt);
      request_type r;
      r.typ = typ;
      r.slot = slot;
      r.kind = kind;
      for (int l = 0; l < wnts_pkg::LANES; l++) begin
         r.vals[l] = val;
         r.wts[l] = wt;
      end
      return r;
   endfunction

   function automatic request_type make_load(logic [wnts_pkg::IDX_W-1:0] slot);
      request_type r;
      r = uniform_request(wnts_pkg::REQ_LOAD, slot, 8'($urandom), '0, '0);
      for (int l = 0; l < wnts_pkg::LANES; l++) begin
         r.vals[l] = rand_value();
         r.wts[l] = rand_weight();
      end
      return r;
   endfunction

   // query with random sample; load-only fields carry noise
   function automatic request_type make_query();
      request_type r;
      r = make_load(6'($urandom));
      r.typ = wnts_pkg::REQ_QUERY;
      return r;
   endfunction

   // drive one request, wait for it to be taken, then maybe idle
   task automatic issue(request_type r);
      start <= 1'b1;
      req_type <= r.typ;
      req_entry_index <= r.slot;
      req_entry_kind <= r.kind;
      req_value_temperature <= r.vals[0];
      req_value_humidity <= r.vals[1];
      req_value_erosion <= r.vals[2];
      req_value_weirdness <= r.vals[3];
      req_weight_temperature <= r.wts[0];
      req_weight_humidity <= r.wts[1];
      req_weight_erosion <= r.wts[2];
      req_weight_weirdness <= r.wts[3];
      do @(posedge clock); while (busy);
      board.note_request(r);
      if (r.typ == wnts_pkg::REQ_LOAD) loaded[r.slot] = 1'b1;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   // wait for all predicted hits plus a full scan worth of cycles
   task automatic settle_idle();
      start <= 1'b0;
      while (board.pending() != 0 || busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // csr write; valid is left high for the caller to drop
   task automatic csr_write(logic [wnts_pkg::CSR_IDX_W-1:0] idx,
                            logic [wnts_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(idx, data);
   endtask

   // new register setting, only while the block is idle
   task automatic configure(logic [7:0] count, logic [7:0] keep, logic [7:0] kind, bit bad);
      settle_idle();
      if (bad) csr_write(CSR_UNUSED, 8'($urandom));
      csr_write(wnts_pkg::CSR_ENTRY_COUNT, count);
      csr_write(wnts_pkg::CSR_KEEP_COUNT, keep);
      csr_write(wnts_pkg::CSR_DEFAULT_KIND, kind);
      csr_valid <= 1'b0;
   endtask

   // random segments: a setting, the loads it needs, then a burst of requests
   task automatic run_phase(int pct, int items);
      int done, n, burst;
      logic [6:0] count;
      logic [7:0] kind;
      done = 0;
      sender_idle_pct = pct;
      while (done < items) begin
         case ($urandom_range(0, 9))
            0: count = 7'd0;
            1, 2, 3, 4, 5, 6: count = 7'($urandom_range(1, 8));
            7, 8: count = 7'($urandom_range(9, 63));
            default: count = 7'($urandom_range(64, 127));
         endcase
         // one scan past the table end early on
         if (!full_scan_done) begin
            count = 7'd127;
            full_scan_done = 1'b1;
         end
         case ($urandom_range(0, 3))
            0: kind = 8'h00;
            1: kind = 8'hff;
            default: kind = 8'($urandom);
         endcase
         configure({1'($urandom), count}, {5'($urandom), 3'($urandom_range(0, 7))}, kind,
            $urandom_range(0, 3) == 0);
         // never scan a slot that was never loaded
         n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         for (int s = 0; s < n; s++) begin
            if (!loaded[s]) begin
               issue(make_load(6'(s)));
               done++;
            end
         end
         burst = $urandom_range(3, 10);
         repeat (burst) begin
            if ($urandom_range(0, 9) < 7) issue(make_query());
            else issue(make_load(6'($urandom)));
            done++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table with reset settings, then with an all-ones default kind
      issue(uniform_request(wnts_pkg::REQ_QUERY, 6'd0, 8'h00, 16'h8000, 16'h0000));
      configure(8'h80, 8'h01, 8'hff, 1'b1);
      issue(uniform_request(wnts_pkg::REQ_QUERY, 6'd63, 8'hff, 16'h7fff, 16'hffff));

      // extreme centres and weights, a tied pair, both ends of the slot range
      issue(uniform_request(wnts_pkg::REQ_LOAD, 6'd0, 8'h11, 16'h8000, 16'hffff));
      issue(uniform_request(wnts_pkg::REQ_LOAD, 6'd1, 8'hee, 16'h7fff, 16'hffff));
      issue(uniform_request(wnts_pkg::REQ_LOAD, 6'd2, 8'h22, 16'h0000, 16'h0000));
      issue(uniform_request(wnts_pkg::REQ_LOAD, 6'd3, 8'h33, 16'h0000, 16'h0000));
      issue(make_load(6'd4));
      issue(make_load(6'd63));

      // full list, largest distance and tied nearest entries
      configure(8'd5, 8'd4, 8'ha5, 1'b0);
      issue(uniform_request(wnts_pkg::REQ_QUERY, 6'd0, 8'h00, 16'h8000, 16'h0000));
      issue(uniform_request(wnts_pkg::REQ_QUERY, 6'd0, 8'h00, 16'h7fff, 16'h0000));
      issue(uniform_request(wnts_pkg::REQ_QUERY, 6'd0, 8'h00, 16'h0000, 16'h0000));

      // keep count of zero acts as one
      configure(8'd5, 8'd0, 8'h5a, 1'b0);
      issue(make_query());
      // keep count above the list size saturates
      configure(8'd5, 8'hff, 8'h5a, 1'b0);
      issue(make_query());
      // fewer entries than the keep count
      configure(8'd2, 8'd4, 8'h00, 1'b0);
      issue(uniform_request(wnts_pkg::REQ_QUERY, 6'd0, 8'h00, 16'h0000, 16'h0000));
      // single best pick
      configure(8'd1, 8'd1, 8'h00, 1'b0);
      issue(make_query());

      run_phase(24, 85);
      run_phase(83, 85);
      run_phase(0, 85);

      settle_idle();
      if (board.pending() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, board.pending());
         board.failures++;
      end
      if (board.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
